/* rtl/core/mhic_pkg.sv */
// ----------------------------------------------------------------------------
// mhic_pkg
// Shared types and constants of the hard-iron magnetometer calibrator.
// ----------------------------------------------------------------------------
package mhic_pkg;

   // sample word width used for the extreme stores
   localparam int SAMPLE_WIDTH = 16;
   localparam int SPAN_WIDTH   = SAMPLE_WIDTH + 1;

   localparam int FIELD_WIDTH  = 16;
   localparam int CFG_WIDTH    = 16;
   localparam int CNT_WIDTH    = 16;
   localparam int PROG_WIDTH   = 7;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

   localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // progress split
   localparam int XY_PART     = 70;
   localparam int STABLE_PART = 30;
   localparam int FULL        = 100;

   // progress divider: quotient is below XY_PART whenever used, so 7 quotient bits
   localparam int QUOT_WIDTH      = 7;
   localparam int DIVD_WIDTH      = CFG_WIDTH + QUOT_WIDTH;
   localparam int DIV_STEPS       = QUOT_WIDTH;
   localparam int STEP_CNT_WIDTH  = $clog2(DIV_STEPS);

   // item kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;
   localparam logic [1:0] KIND_NOP    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MIN_XY_SPAN      = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MIN_Z_SPAN       = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MIN_SAMPLE_COUNT = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_STABLE_NEEDED    = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PRIOR_Z_OFFSET   = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PRIOR_VALID      = 3'd5;

   // register reset values
   localparam logic [CFG_WIDTH-1:0] RST_MIN_XY_SPAN      = 16'd320;
   localparam logic [CFG_WIDTH-1:0] RST_MIN_Z_SPAN       = 16'd128;
   localparam logic [CFG_WIDTH-1:0] RST_MIN_SAMPLE_COUNT = 16'd80;
   localparam logic [CFG_WIDTH-1:0] RST_STABLE_NEEDED    = 16'd100;

   typedef struct packed {
      logic [1:0]                    kind;
      logic signed [FIELD_WIDTH-1:0] raw_x;
      logic signed [FIELD_WIDTH-1:0] raw_y;
      logic signed [FIELD_WIDTH-1:0] raw_z;
      logic signed [FIELD_WIDTH-1:0] field_x;
      logic signed [FIELD_WIDTH-1:0] field_y;
      logic signed [FIELD_WIDTH-1:0] field_z;
   } req_type;

   typedef struct packed {
      logic                          calibrating;
      logic [PROG_WIDTH-1:0]         progress;
      logic                          finished;
      logic signed [FIELD_WIDTH-1:0] offset_x;
      logic signed [FIELD_WIDTH-1:0] offset_y;
      logic signed [FIELD_WIDTH-1:0] offset_z;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic prep;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sample_op;
   } sts_type;

endpackage

/* rtl/core/magnetometer_hard_iron_calibrator.sv */
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_calibrator
// Min/max midpoint hard-iron calibration of a three-axis magnetometer.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one item (sample, start, cancel or no-op) per handshake.
//    rsp_* returns exactly one result item for every accepted item, in order.
//  - csr_* writes the thresholds and the prior Z offset; write only while the
//    block is idle (all results delivered).
//  - A sample taken while armed passes execute, prepare, the 7-step restoring
//    divider for progress and the result load; every other item passes
//    execute and the result load. The next item is taken only once the
//    previous one has loaded its result.
//  - The result register parts the two sides: once a result is loaded the
//    block takes the next item even if rsp_ready is low; that item then waits
//    in its last step until the held result is taken, and req_ready stays low.
//  - Reset (synchronous) disarms, loads the register defaults and empties the
//    result register. The extreme stores are cleared by a start item.
//  - Start while armed is ignored; cancel disarms; samples while idle only
//    echo the armed flag with zero progress.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mhic_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mhic_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [mhic_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [mhic_pkg::CFG_WIDTH-1:0]     csr_wdata
);

   mhic_pkg::cmd_type cmd;
   mhic_pkg::sts_type sts;

   // sequencer: item handshake, step order, result valid
   mhic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stores, counters, divider and result payload
   mhic_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

/* rtl/core/mhic_ctrl.sv */
// ----------------------------------------------------------------------------
// mhic_ctrl
// Sequencer: capture, execute; prepare, divide (armed samples); result out.
// ----------------------------------------------------------------------------
module mhic_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mhic_pkg::sts_type sts,
   output mhic_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_HOLD = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [mhic_pkg::STEP_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.sample_op ? ST_PREP : ST_HOLD;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = mhic_pkg::STEP_CNT_WIDTH'(mhic_pkg::DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load_out)
      else $error("result overwritten while stalled");

   // an accepted item always leads through execute
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (cmd.exec && !req_ready))
      else $error("accepted item not executed");

endmodule

/* rtl/core/mhic_dpath.sv */
// ----------------------------------------------------------------------------
// mhic_dpath
// Extreme stores, counters, config registers, progress divider, result reg.
// ----------------------------------------------------------------------------
module mhic_dpath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mhic_pkg::cmd_type                        cmd,
   output mhic_pkg::sts_type                        sts,
   input  mhic_pkg::req_type                        req_data,
   output mhic_pkg::rsp_type                        rsp_data,
   input  logic                                     csr_we,
   input  logic [mhic_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  logic [mhic_pkg::CFG_WIDTH-1:0]           csr_wdata
);

   localparam int SW  = mhic_pkg::SAMPLE_WIDTH;
   localparam int SPW = mhic_pkg::SPAN_WIDTH;
   localparam int CW  = mhic_pkg::CFG_WIDTH;
   localparam int NW  = mhic_pkg::CNT_WIDTH;
   localparam int DW  = mhic_pkg::DIVD_WIDTH;
   localparam int QW  = mhic_pkg::QUOT_WIDTH;
   localparam int PW  = mhic_pkg::PROG_WIDTH;
   localparam int FW  = mhic_pkg::FIELD_WIDTH;

   // midpoint, truncated toward zero
   function automatic logic signed [SW-1:0] midpoint(input logic signed [SW-1:0] hi,
                                                      input logic signed [SW-1:0] lo);
      logic signed [SPW-1:0] s;
      logic signed [SPW-1:0] t;
      s = SPW'(hi) + SPW'(lo);
      t = s + SPW'(s[SPW-1]);
      return SW'(t >>> 1);
   endfunction

   mhic_pkg::req_type item_ff, item_in;
   mhic_pkg::rsp_type rsp_ff, rsp_in;

   // configuration
   logic [CW-1:0]        mxy_ff, mxy_in, mzs_ff, mzs_in, msc_ff, msc_in, sn_ff, sn_in;
   logic signed [FW-1:0] pz_ff, pz_in;
   logic                 pv_ff, pv_in;

   // calibration state
   logic                 armed_ff, armed_in;
   logic [NW-1:0]        scnt_ff, scnt_in, stcnt_ff, stcnt_in;
   logic signed [SW-1:0] raw_lo_ff [3], raw_lo_in [3];
   logic signed [SW-1:0] raw_hi_ff [3], raw_hi_in [3];
   logic signed [SW-1:0] fld_lo_ff [3], fld_lo_in [3];
   logic signed [SW-1:0] fld_hi_ff [3], fld_hi_in [3];

   // per-item working registers
   logic                 samp_ff, samp_in;
   logic                 quick_ff, quick_in;
   logic [PW-1:0]        qval_ff, qval_in;
   logic                 rdy_ff, rdy_in;
   logic                 fin_ff, fin_in;
   logic signed [FW-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [DW-1:0]        rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QW-1:0]        q_ff, q_in;

   // combinational helpers
   logic signed [SW-1:0] smp_raw [3];
   logic signed [SW-1:0] smp_fld [3];
   logic                 changed;
   logic [SPW-1:0]       span [3];
   logic [SPW-1:0]       mn;
   logic                 rdy_c, fin_c, ge;
   logic [CW-1:0]        mn_c;

   assign smp_raw[0] = SW'(item_ff.raw_x);
   assign smp_raw[1] = SW'(item_ff.raw_y);
   assign smp_raw[2] = SW'(item_ff.raw_z);
   assign smp_fld[0] = SW'(item_ff.field_x);
   assign smp_fld[1] = SW'(item_ff.field_y);
   assign smp_fld[2] = SW'(item_ff.field_z);

   assign sts.sample_op = (item_ff.kind == mhic_pkg::KIND_SAMPLE) && armed_ff;
   assign rsp_data      = rsp_ff;

   // spans are never negative once a sample has been taken
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         span[i] = SPW'(fld_hi_ff[i]) - SPW'(fld_lo_ff[i]);
      end
      mn    = (span[0] < span[1]) ? span[0] : span[1];
      mn_c  = CW'(mn);
      rdy_c = (span[0] >= SPW'(mxy_ff)) && (span[1] >= SPW'(mxy_ff)) &&
              (scnt_ff >= NW'(msc_ff));
      fin_c = rdy_c && (stcnt_ff >= NW'(sn_ff));
      ge    = rem_ff >= dsh_ff;
   end

   always_comb begin
      item_in  = item_ff;
      rsp_in   = rsp_ff;
      mxy_in   = mxy_ff;
      mzs_in   = mzs_ff;
      msc_in   = msc_ff;
      sn_in    = sn_ff;
      pz_in    = pz_ff;
      pv_in    = pv_ff;
      armed_in = armed_ff;
      scnt_in  = scnt_ff;
      stcnt_in = stcnt_ff;
      raw_lo_in = raw_lo_ff;
      raw_hi_in = raw_hi_ff;
      fld_lo_in = fld_lo_ff;
      fld_hi_in = fld_hi_ff;
      samp_in  = samp_ff;
      quick_in = quick_ff;
      qval_in  = qval_ff;
      rdy_in   = rdy_ff;
      fin_in   = fin_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oz_in    = oz_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      changed  = 1'b0;

      if (csr_we) begin
         case (csr_index)
            mhic_pkg::REG_MIN_XY_SPAN:      mxy_in = csr_wdata;
            mhic_pkg::REG_MIN_Z_SPAN:       mzs_in = csr_wdata;
            mhic_pkg::REG_MIN_SAMPLE_COUNT: msc_in = csr_wdata;
            mhic_pkg::REG_STABLE_NEEDED:    sn_in  = csr_wdata;
            mhic_pkg::REG_PRIOR_Z_OFFSET:   pz_in  = FW'(csr_wdata);
            mhic_pkg::REG_PRIOR_VALID:      pv_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         item_in = req_data;
      end

      if (cmd.exec) begin
         samp_in = sts.sample_op;
         case (item_ff.kind)
            mhic_pkg::KIND_START: begin
               if (!armed_ff) begin
                  armed_in = 1'b1;
                  scnt_in  = '0;
                  stcnt_in = '0;
                  for (int i = 0; i < 3; i++) begin
                     raw_lo_in[i] = mhic_pkg::MOST_POS;
                     raw_hi_in[i] = mhic_pkg::MOST_NEG;
                     fld_lo_in[i] = mhic_pkg::MOST_POS;
                     fld_hi_in[i] = mhic_pkg::MOST_NEG;
                  end
               end
            end
            mhic_pkg::KIND_CANCEL: begin
               armed_in = 1'b0;
            end
            mhic_pkg::KIND_SAMPLE: begin
               if (armed_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     if (smp_raw[i] < raw_lo_ff[i]) begin
                        raw_lo_in[i] = smp_raw[i];
                        changed      = 1'b1;
                     end
                     if (smp_raw[i] > raw_hi_ff[i]) begin
                        raw_hi_in[i] = smp_raw[i];
                        changed      = 1'b1;
                     end
                     if (smp_fld[i] < fld_lo_ff[i]) fld_lo_in[i] = smp_fld[i];
                     if (smp_fld[i] > fld_hi_ff[i]) fld_hi_in[i] = smp_fld[i];
                  end
                  if (scnt_ff != mhic_pkg::CNT_MAX) scnt_in = scnt_ff + 1'b1;
                  if (changed) begin
                     stcnt_in = '0;
                  end else if (stcnt_ff != mhic_pkg::CNT_MAX) begin
                     stcnt_in = stcnt_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      if (cmd.prep) begin
         rdy_in = rdy_c;
         fin_in = fin_c;
         q_in   = '0;
         dsh_in = DW'({sn_ff, {(QW-1){1'b0}}});
         rem_in = DW'(stcnt_ff) * DW'(mhic_pkg::STABLE_PART);
         if (rdy_c) begin
            // stable count at target or beyond caps the stability part
            quick_in = stcnt_ff >= NW'(sn_ff);
            qval_in  = PW'(mhic_pkg::FULL);
         end else begin
            quick_in = (mxy_ff == '0) || (mn >= SPW'(mxy_ff));
            qval_in  = PW'(mhic_pkg::XY_PART);
            dsh_in   = DW'({mxy_ff, {(QW-1){1'b0}}});
            rem_in   = DW'(mn_c) * DW'(mhic_pkg::XY_PART);
         end
         ox_in = FW'(midpoint(raw_hi_ff[0], raw_lo_ff[0]));
         oy_in = FW'(midpoint(raw_hi_ff[1], raw_lo_ff[1]));
         if (span[2] >= SPW'(mzs_ff)) begin
            oz_in = FW'(midpoint(raw_hi_ff[2], raw_lo_ff[2]));
         end else if (pv_ff) begin
            oz_in = pz_ff;
         end else begin
            oz_in = '0;
         end
         if (fin_c) armed_in = 1'b0;
      end

      // restoring division, one quotient bit a step
      if (cmd.div_step) begin
         if (ge) rem_in = rem_ff - dsh_ff;
         q_in   = {q_ff[QW-2:0], ge};
         dsh_in = dsh_ff >> 1;
      end

      if (cmd.load_out) begin
         rsp_in             = '0;
         rsp_in.calibrating = armed_ff;
         if (samp_ff) begin
            if (quick_ff) begin
               rsp_in.progress = qval_ff;
            end else if (rdy_ff) begin
               rsp_in.progress = PW'(mhic_pkg::XY_PART) + PW'(q_ff);
            end else begin
               rsp_in.progress = PW'(q_ff);
            end
            if (fin_ff) begin
               rsp_in.finished = 1'b1;
               rsp_in.offset_x = ox_ff;
               rsp_in.offset_y = oy_ff;
               rsp_in.offset_z = oz_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mxy_ff   <= mhic_pkg::RST_MIN_XY_SPAN;
         mzs_ff   <= mhic_pkg::RST_MIN_Z_SPAN;
         msc_ff   <= mhic_pkg::RST_MIN_SAMPLE_COUNT;
         sn_ff    <= mhic_pkg::RST_STABLE_NEEDED;
         pz_ff    <= '0;
         pv_ff    <= 1'b0;
         armed_ff <= 1'b0;
      end else begin
         mxy_ff   <= mxy_in;
         mzs_ff   <= mzs_in;
         msc_ff   <= msc_in;
         sn_ff    <= sn_in;
         pz_ff    <= pz_in;
         pv_ff    <= pv_in;
         armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      rsp_ff    <= rsp_in;
      scnt_ff   <= scnt_in;
      stcnt_ff  <= stcnt_in;
      raw_lo_ff <= raw_lo_in;
      raw_hi_ff <= raw_hi_in;
      fld_lo_ff <= fld_lo_in;
      fld_hi_ff <= fld_hi_in;
      samp_ff   <= samp_in;
      quick_ff  <= quick_in;
      qval_ff   <= qval_in;
      rdy_ff    <= rdy_in;
      fin_ff    <= fin_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      oz_ff     <= oz_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      q_ff      <= q_in;
   end

   // a loaded result never reports more than full progress
   a_prog_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (rsp_ff.progress <= PW'(mhic_pkg::FULL)))
      else $error("progress above full scale");

   // a finished result reports full progress and a disarmed block
   a_finish_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && samp_ff && fin_ff) |=>
      (rsp_ff.progress == PW'(mhic_pkg::FULL) && !rsp_ff.calibrating && !armed_ff))
      else $error("finish without full progress or still armed");

   // after a sample update the raw stores are ordered
   a_raw_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && sts.sample_op) |=>
      (raw_lo_ff[0] <= raw_hi_ff[0] && raw_lo_ff[1] <= raw_hi_ff[1] &&
       raw_lo_ff[2] <= raw_hi_ff[2]))
      else $error("raw extreme stores out of order");

endmodule

/* bench/magnetometer_hard_iron_calibrator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_calibrator_checker
// Watches the item and result channels and the register port. It tracks its
// own copy of the calibration state, predicts one result per accepted item
// and compares every delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator_checker
   import mhic_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_wdata,
   output int unsigned              mismatches,
   output int unsigned              results_pending,
   output int unsigned              results_seen,
   output int unsigned              finishes_seen
);

   // register copies
   int xy_span_min;
   int z_span_min;
   int count_min;
   int stable_min;
   logic signed [15:0] prior_z;
   logic prior_ok;

   // calibration state
   logic armed;
   int n_samples;
   int n_stable;
   int raw_lo[3];
   int raw_hi[3];
   int fld_lo[3];
   int fld_hi[3];

   rsp_type offsets_due_q[$];

   function automatic void clear_extremes();
      int a;
      n_samples = 0;
      n_stable  = 0;
      for (a = 0; a < 3; a++) begin
         raw_lo[a] = MOST_POS;
         raw_hi[a] = MOST_NEG;
         fld_lo[a] = MOST_POS;
         fld_hi[a] = MOST_NEG;
      end
   endfunction

   // next calibration state and the result of one item
   function automatic rsp_type advance_calibration(req_type it);
      rsp_type r;
      int raw_v[3];
      int fld_v[3];
      int a;
      int xs;
      int ys;
      int zs;
      int least;
      int pct;
      logic moved;
      logic ready;
      r = '0;
      raw_v[0] = $signed(it.raw_x);
      raw_v[1] = $signed(it.raw_y);
      raw_v[2] = $signed(it.raw_z);
      fld_v[0] = $signed(it.field_x);
      fld_v[1] = $signed(it.field_y);
      fld_v[2] = $signed(it.field_z);
      case (it.kind)
         KIND_START: begin
            if (!armed) begin
               clear_extremes();
               armed = 1'b1;
            end
         end
         KIND_CANCEL: begin
            armed = 1'b0;
         end
         KIND_SAMPLE: begin
            if (armed) begin
               moved = 1'b0;
               for (a = 0; a < 3; a++) begin
                  if (raw_v[a] < raw_lo[a]) begin
                     raw_lo[a] = raw_v[a];
                     moved = 1'b1;
                  end
                  if (raw_v[a] > raw_hi[a]) begin
                     raw_hi[a] = raw_v[a];
                     moved = 1'b1;
                  end
                  if (fld_v[a] < fld_lo[a]) fld_lo[a] = fld_v[a];
                  if (fld_v[a] > fld_hi[a]) fld_hi[a] = fld_v[a];
               end
               if (n_samples < CNT_MAX) n_samples++;
               if (moved) n_stable = 0;
               else if (n_stable < CNT_MAX) n_stable++;

               xs = fld_hi[0] - fld_lo[0];
               ys = fld_hi[1] - fld_lo[1];
               zs = fld_hi[2] - fld_lo[2];
               least = (xs < ys) ? xs : ys;
               ready = (xs >= xy_span_min) && (ys >= xy_span_min) && (n_samples >= count_min);
               if (ready) begin
                  pct = (stable_min == 0) ? FULL : XY_PART + n_stable * STABLE_PART / stable_min;
                  if (pct > FULL) pct = FULL;
               end else if (least < 0) begin
                  pct = 0;
               end else if (xy_span_min == 0 || least >= xy_span_min) begin
                  pct = XY_PART;
               end else begin
                  pct = least * XY_PART / xy_span_min;
               end
               r.progress = 7'(pct);

               if (ready && n_stable >= stable_min) begin
                  r.finished = 1'b1;
                  // int division truncates toward zero, as the midpoint must
                  r.offset_x = 16'((raw_hi[0] + raw_lo[0]) / 2);
                  r.offset_y = 16'((raw_hi[1] + raw_lo[1]) / 2);
                  if (zs >= z_span_min) r.offset_z = 16'((raw_hi[2] + raw_lo[2]) / 2);
                  else if (prior_ok) r.offset_z = prior_z;
                  else r.offset_z = '0;
                  armed = 1'b0;
               end
            end
         end
         default: ;
      endcase
      r.calibrating = armed;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                   results_seen, name, got, want));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (offsets_due_q.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                   results_seen));
         return;
      end
      want = offsets_due_q.pop_front();
      compare_field("calibrating", 16'(got.calibrating), 16'(want.calibrating));
      compare_field("progress",    16'(got.progress),    16'(want.progress));
      compare_field("finished",    16'(got.finished),    16'(want.finished));
      compare_field("offset_x",    got.offset_x,         want.offset_x);
      compare_field("offset_y",    got.offset_y,         want.offset_y);
      compare_field("offset_z",    got.offset_z,         want.offset_z);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         xy_span_min = RST_MIN_XY_SPAN;
         z_span_min  = RST_MIN_Z_SPAN;
         count_min   = RST_MIN_SAMPLE_COUNT;
         stable_min  = RST_STABLE_NEEDED;
         prior_z     = '0;
         prior_ok    = 1'b0;
         armed       = 1'b0;
         clear_extremes();
         offsets_due_q.delete();
         mismatches    = 0;
         results_seen  = 0;
         finishes_seen = 0;
      end else begin
         // a result can never belong to the item taken at the same edge
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
            results_seen++;
            if (rsp_data.finished === 1'b1) finishes_seen++;
         end
         if (csr_we) begin
            case (csr_index)
               REG_MIN_XY_SPAN:      xy_span_min = csr_wdata;
               REG_MIN_Z_SPAN:       z_span_min  = csr_wdata;
               REG_MIN_SAMPLE_COUNT: count_min   = csr_wdata;
               REG_STABLE_NEEDED:    stable_min  = csr_wdata;
               REG_PRIOR_Z_OFFSET:   prior_z     = csr_wdata;
               REG_PRIOR_VALID:      prior_ok    = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) offsets_due_q.push_back(advance_calibration(req_data));
      end
      results_pending <= offsets_due_q.size();
   end

endmodule

/* bench/magnetometer_hard_iron_calibrator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_calibrator_tb
// Drives items and register writes into the hard-iron calibrator: a directed
// set of edge cases, then random calibration sessions under three handshake
// pacing patterns.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator_tb;
   import mhic_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400_000;
   // settling margin after the last result, so the block is sure to go quiet
   localparam int DRAIN_CYCLES = 16;
   // indexes with no register behind them
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UNUSED_HI = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]     csr_wdata = '0;

   int unsigned mismatches;
   int unsigned results_pending;
   int unsigned results_seen;
   int unsigned finishes_seen;

   // pacing: chance in percent that a side holds off in a given cycle
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;

   // what the registers hold now; only used to size the sessions
   int cfg_xy = RST_MIN_XY_SPAN;
   int cfg_z = RST_MIN_Z_SPAN;
   int cfg_cnt = RST_MIN_SAMPLE_COUNT;
   int cfg_stable = RST_STABLE_NEEDED;

   magnetometer_hard_iron_calibrator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   magnetometer_hard_iron_calibrator_checker offset_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .results_pending (results_pending),
      .results_seen    (results_seen),
      .finishes_seen   (finishes_seen)
   );

   always #10 clock = ~clock;

   // result side: ready drops at random per the current pacing
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, results_pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_type make_item(input logic [1:0] kind, input int rx, input int ry,
                                         input int rz, input int fx, input int fy,
                                         input int fz);
      req_type it;
      it.kind    = kind;
      it.raw_x   = 16'(rx);
      it.raw_y   = 16'(ry);
      it.raw_z   = 16'(rz);
      it.field_x = 16'(fx);
      it.field_y = 16'(fy);
      it.field_z = 16'(fz);
      return it;
   endfunction

   // any payload at all
   function automatic req_type rand_item(input logic [1:0] kind);
      return make_item(kind, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // sample within the raw box or on its edge (no new raw extreme) and the field box
   function automatic req_type box_item(input int cx, input int cy, input int cz, input int rr,
                                        input int fx, input int fy, input int fz, input int fr,
                                        input int fzr);
      return make_item(KIND_SAMPLE,
                       cx - rr + $urandom_range(2 * rr), cy - rr + $urandom_range(2 * rr),
                       cz - rr + $urandom_range(2 * rr), fx - fr + $urandom_range(2 * fr),
                       fy - fr + $urandom_range(2 * fr), fz - fzr + $urandom_range(2 * fzr));
   endfunction

   // Called at a clock edge; returns at the edge where the item is taken.
   // Valid is only lowered for a gap, never in the step that raises it.
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // stop sending and wait for every outstanding result, then let it settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx, input int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(val);
      @(posedge clock);
   endtask

   // rewrites every register, plus junk to the unused indexes
   task automatic set_config(input int xy, input int z, input int cnt, input int stab,
                             input int prior, input int pvalid);
      wait_idle();
      write_reg(REG_UNUSED_LO, $urandom);
      write_reg(REG_MIN_XY_SPAN, xy);
      write_reg(REG_MIN_Z_SPAN, z);
      write_reg(REG_MIN_SAMPLE_COUNT, cnt);
      write_reg(REG_STABLE_NEEDED, stab);
      write_reg(REG_PRIOR_Z_OFFSET, prior);
      write_reg(REG_PRIOR_VALID, pvalid);
      write_reg(REG_UNUSED_HI, $urandom);
      csr_we <= 1'b0;
      cfg_xy     = xy & 16'hFFFF;
      cfg_z      = z & 16'hFFFF;
      cfg_cnt    = cnt & 16'hFFFF;
      cfg_stable = stab & 16'hFFFF;
   endtask

   // Random calibration sessions: new settings at times, start, a sweep that sets
   // the raw extremes, then settling samples inside the box with a little noise.
   task automatic run_sessions(input int unsigned quota);
      int unsigned goal;
      int cx, cy, cz, rr;
      int fx0, fy0, fz0, fr, fzr;
      int v_xy, v_z, v_cnt, v_stab;
      int n_sweep, n_settle, k;
      logic aborted;
      goal = items_sent + quota;
      while (items_sent < goal) begin
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(7))
               0:       v_xy = 0;
               1:       v_xy = 1;
               2:       v_xy = 65535;
               default: v_xy = $urandom_range(1, 800);
            endcase
            case ($urandom_range(7))
               0:       v_z = 0;
               1:       v_z = 65535;
               default: v_z = $urandom_range(1, 800);
            endcase
            case ($urandom_range(7))
               0:       v_cnt = 0;
               1:       v_cnt = 1;
               default: v_cnt = $urandom_range(1, 30);
            endcase
            case ($urandom_range(7))
               0:       v_stab = 0;
               1:       v_stab = 1;
               default: v_stab = $urandom_range(1, 25);
            endcase
            set_config(v_xy, v_z, v_cnt, v_stab, $urandom, $urandom_range(1));
         end

         cx  = $urandom_range(40000) - 20000;
         cy  = $urandom_range(40000) - 20000;
         cz  = $urandom_range(40000) - 20000;
         fx0 = $urandom_range(40000) - 20000;
         fy0 = $urandom_range(40000) - 20000;
         fz0 = $urandom_range(40000) - 20000;
         fr  = $urandom_range(cfg_xy > 24000 ? 12000 : cfg_xy / 2 + 40);
         fzr = $urandom_range(cfg_z > 24000 ? 12000 : cfg_z / 2 + 40);
         if ($urandom_range(9) == 0) begin
            // full-scale sweep on every axis
            cx = 0; cy = 0; cz = 0; rr = 32767;
            fx0 = 0; fy0 = 0; fz0 = 0; fr = 32767; fzr = 32767;
         end else if ($urandom_range(1) == 0) begin
            rr = $urandom_range(12000);
         end else begin
            rr = $urandom_range(40);
         end

         send_item(rand_item(KIND_START));
         n_sweep = $urandom_range(2, 8);
         for (k = 0; k < n_sweep; k++) begin
            if (k == 0)
               send_item(make_item(KIND_SAMPLE, cx - rr, cy - rr, cz - rr,
                                   fx0 - fr, fy0 - fr, fz0 - fzr));
            else if (k == n_sweep - 1)
               send_item(make_item(KIND_SAMPLE, cx + rr, cy + rr, cz + rr,
                                   fx0 + fr, fy0 + fr, fz0 + fzr));
            else
               send_item(box_item(cx, cy, cz, rr, fx0, fy0, fz0, fr, fzr));
         end

         // enough settling samples to finish when the spans allow it
         n_settle = (cfg_stable > cfg_cnt - n_sweep) ? cfg_stable : cfg_cnt - n_sweep;
         n_settle = n_settle + $urandom_range(3);
         if (n_settle > 60) n_settle = 60;
         aborted = 1'b0;
         for (k = 0; k < n_settle && !aborted; k++) begin
            case ($urandom_range(49))
               0: send_item(rand_item(KIND_NOP));
               1: send_item(rand_item(KIND_START));   // ignored while armed
               2: send_item(make_item(KIND_SAMPLE, cx + rr + 1, cy, cz, fx0, fy0, fz0));
               3: begin
                  send_item(rand_item(KIND_CANCEL));
                  aborted = 1'b1;
               end
               default: send_item(box_item(cx, cy, cz, rr, fx0, fy0, fz0, fr, fzr));
            endcase
         end

         // stray items between sessions; a stray start leaves the block armed
         repeat ($urandom_range(2)) send_item(rand_item(2'($urandom_range(3))));
      end
   endtask

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- phase A: sender idles lightly, receiver stalls heavily ----
      send_idle_pct = 10;
      recv_idle_pct = 73;

      // Directed part. Short stability target, one sample needed.
      set_config(200, 65535, 1, 2, -32768, 1);
      send_item(make_item(KIND_SAMPLE, 32767, 32767, 32767, 32767, 32767, 32767)); // idle
      send_item(rand_item(KIND_CANCEL));                                           // idle
      send_item(make_item(KIND_NOP, -32768, -32768, -32768, -32768, -32768, -32768));
      send_item(make_item(KIND_START, 0, 0, 0, 0, 0, 0));
      send_item(make_item(KIND_START, -1, -1, -1, -1, -1, -1));                    // armed
      // full-scale extremes; Z field span short of the target, so prior Z wins
      send_item(make_item(KIND_SAMPLE, 32767, 32767, 32767, 32767, 32767, 32767));
      send_item(make_item(KIND_SAMPLE, -32768, -32768, -32768, -32768, -32768, 0));
      send_item(make_item(KIND_SAMPLE, 0, 0, 0, 0, 0, 0));
      send_item(make_item(KIND_SAMPLE, 0, 0, 0, 0, 0, 0));                         // finishes
      send_item(make_item(KIND_SAMPLE, 0, 0, 0, 0, 0, 0));                         // idle echo
      // partial X/Y progress, odd negative midpoints, full Z span, capped progress
      send_item(make_item(KIND_START, 0, 0, 0, 0, 0, 0));
      send_item(make_item(KIND_SAMPLE, 5, -5, 7, 0, 0, -32768));
      send_item(make_item(KIND_SAMPLE, -8, 2, -4, 150, 199, 32767));
      send_item(make_item(KIND_SAMPLE, 0, 0, 0, 199, 0, 0));
      send_item(make_item(KIND_SAMPLE, 0, 0, 0, 200, 0, 0));
      send_item(make_item(KIND_SAMPLE, 0, 0, 0, 0, 200, 0));
      // zero span and stability targets: finishes on the first sample, Z zero
      set_config(0, 1, 0, 0, 1234, 0);
      send_item(make_item(KIND_START, 0, 0, 0, 0, 0, 0));
      send_item(make_item(KIND_SAMPLE, -32768, 32767, 1, 5, 5, 5));
      // zero span target while still short of samples
      set_config(0, 1, 3, 0, 1234, 1);
      send_item(make_item(KIND_START, 0, 0, 0, 0, 0, 0));
      for (n = 0; n < 3; n++) send_item(make_item(KIND_SAMPLE, n, -n, 3, 9, 9, 9));
      // cancel while armed, then a sample that is only echoed
      send_item(make_item(KIND_START, 0, 0, 0, 0, 0, 0));
      send_item(make_item(KIND_SAMPLE, 100, 100, 100, 100, 100, 100));
      send_item(rand_item(KIND_CANCEL));
      send_item(make_item(KIND_SAMPLE, 100, 100, 100, 100, 100, 100));

      set_config(RST_MIN_XY_SPAN, RST_MIN_Z_SPAN, 20, 15, $urandom, 1);
      run_sessions(540);

      // ---- phase B: sender idles heavily, receiver stalls lightly ----
      send_idle_pct = 73;
      recv_idle_pct = 10;
      run_sessions(580);

      // ---- phase C: no idling on either side ----
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_sessions(540);
      wait_idle();

      $display("Covered %0d items, %0d results checked, %0d calibrations finished",
               items_sent, results_seen, finishes_seen);
      $display("Stalls on each side in turn and none; zero, small and full-scale thresholds");
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/mhic_pkg.sv
rtl/core/mhic_ctrl.sv
rtl/core/mhic_dpath.sv
rtl/core/magnetometer_hard_iron_calibrator.sv
bench/magnetometer_hard_iron_calibrator_checker.sv
bench/magnetometer_hard_iron_calibrator_tb.sv
